/* rtl/hysteresis_peak_valley_detector_top_macros.svh */
// assertion macros for the hysteresis peak/valley detector
// used by the top level; expects clk_i and rst_ni in scope
`ifndef HYSTERESIS_PEAK_VALLEY_DETECTOR_TOP_MACROS_SVH
`define HYSTERESIS_PEAK_VALLEY_DETECTOR_TOP_MACROS_SVH

// same-cycle implication
`define HPVD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HPVD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/hpvd_pkg.sv */
// shared types and constants for the hysteresis peak/valley detector
// no dependencies
`timescale 1ns / 1ps

package hpvd_pkg;

  localparam int unsigned SAMPLE_WIDTH = 24;
  localparam int unsigned INDEX_WIDTH  = 32;
  localparam int unsigned THR_WIDTH    = SAMPLE_WIDTH - 1;
  localparam int unsigned KIND_WIDTH   = 2;

  // queue between front and back
  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_DEPTH = 2 ** QUEUE_PTR_W;
  localparam int unsigned QUEUE_CNT_W = QUEUE_PTR_W + 1;

  typedef enum logic [KIND_WIDTH-1:0] {
    KIND_START  = 2'd0,
    KIND_PEAK   = 2'd1,
    KIND_VALLEY = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    PH_SEARCH = 3'b001,
    PH_MAX    = 3'b010,
    PH_MIN    = 3'b100
  } phase_e;

  // one classified sample on its way to the tracker
  typedef struct packed {
    logic                           first;
    logic [INDEX_WIDTH-1:0]         index;
    logic signed [SAMPLE_WIDTH-1:0] sample;
  } entry_t;

  typedef struct packed {
    logic                   push;
    logic                   full;
    logic                   empty;
    logic [QUEUE_CNT_W-1:0] count;
  } queue_status_t;

  typedef struct packed {
    phase_e phase;
    logic   pop;
  } back_status_t;

endpackage

/* rtl/hpvd_front.sv */
// front end: accepts samples, numbers them and marks the start point
// depends on hpvd_pkg
`timescale 1ns / 1ps

module hpvd_front (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [hpvd_pkg::SAMPLE_WIDTH-1:0] sample_value_i,
  input  logic                                    queue_full_i,
  output logic                                    push_o,
  output hpvd_pkg::entry_t                        entry_o
);

  logic                              started_q, started_d;
  logic [hpvd_pkg::INDEX_WIDTH-1:0]  count_q, count_d;

  // accept whenever the queue has room
  assign in_ready_o = !queue_full_i;
  assign push_o     = in_valid_i && in_ready_o;

  // classify the beat
  assign entry_o.first  = !started_q;
  assign entry_o.index  = count_q;
  assign entry_o.sample = sample_value_i;

  // saturating sample counter
  always_comb begin
    started_d = started_q;
    count_d   = count_q;
    if (push_o) begin
      started_d = 1'b1;
      if (count_q != {hpvd_pkg::INDEX_WIDTH{1'b1}}) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      count_q   <= '0;
    end else begin
      started_q <= started_d;
      count_q   <= count_d;
    end
  end

endmodule

/* rtl/hpvd_queue.sv */
// short queue of classified samples between front and back
// depends on hpvd_pkg
`timescale 1ns / 1ps

module hpvd_queue (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  hpvd_pkg::entry_t         entry_i,
  input  logic                     pop_i,
  output hpvd_pkg::entry_t         head_o,
  output hpvd_pkg::queue_status_t  status_o
);

  hpvd_pkg::entry_t                  mem_q [hpvd_pkg::QUEUE_DEPTH];
  logic [hpvd_pkg::QUEUE_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [hpvd_pkg::QUEUE_CNT_W-1:0]  cnt_q, cnt_d;

  assign status_o.push  = push_i;
  assign status_o.full  = (cnt_q == hpvd_pkg::QUEUE_CNT_W'(hpvd_pkg::QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign status_o.count = cnt_q;
  assign head_o         = mem_q[rd_ptr_q];

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

endmodule

/* rtl/hpvd_back.sv */
// back end: hysteresis tracker and registered event output
// depends on hpvd_pkg
`timescale 1ns / 1ps

module hpvd_back (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic [hpvd_pkg::THR_WIDTH-1:0]           threshold_i,
  input  logic                                     head_valid_i,
  input  hpvd_pkg::entry_t                         head_i,
  output hpvd_pkg::back_status_t                   status_o,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic [hpvd_pkg::KIND_WIDTH-1:0]          event_kind_o,
  output logic [hpvd_pkg::INDEX_WIDTH-1:0]         event_index_o,
  output logic signed [hpvd_pkg::SAMPLE_WIDTH-1:0] event_value_o
);

  localparam int unsigned SW = hpvd_pkg::SAMPLE_WIDTH;
  localparam int unsigned IW = hpvd_pkg::INDEX_WIDTH;

  hpvd_pkg::phase_e        phase_q, phase_d;
  logic signed [SW-1:0]    start_q, start_d;
  logic signed [SW-1:0]    max_q, max_d, min_q, min_d;
  logic [IW-1:0]           max_idx_q, max_idx_d, min_idx_q, min_idx_d;
  logic                    out_valid_q, out_valid_d;
  hpvd_pkg::kind_e         kind_q, kind_d;
  logic [IW-1:0]           idx_q, idx_d;
  logic signed [SW-1:0]    val_q, val_d;

  logic                    pop;
  logic                    emit;
  logic signed [SW:0]      s_ext, thr_ext, d_start, drop, rise;

  // take a new beat when the output register is free or being drained
  assign pop = head_valid_i && (!out_valid_q || out_ready_i);

  // swings, one bit wider than the sample
  assign s_ext   = {head_i.sample[SW-1], head_i.sample};
  assign thr_ext = $signed({2'b00, threshold_i});
  assign d_start = s_ext - {start_q[SW-1], start_q};
  assign drop    = {max_q[SW-1], max_q} - s_ext;
  assign rise    = s_ext - {min_q[SW-1], min_q};

  // tracker update
  always_comb begin
    phase_d   = phase_q;
    start_d   = start_q;
    max_d     = max_q;
    max_idx_d = max_idx_q;
    min_d     = min_q;
    min_idx_d = min_idx_q;
    emit      = 1'b0;
    kind_d    = kind_q;
    idx_d     = idx_q;
    val_d     = val_q;
    if (pop) begin
      if (head_i.first) begin
        start_d = head_i.sample;
        emit    = 1'b1;
        kind_d  = hpvd_pkg::KIND_START;
        idx_d   = head_i.index;
        val_d   = head_i.sample;
      end else begin
        unique case (phase_q)
          hpvd_pkg::PH_SEARCH: begin
            if (d_start > thr_ext) begin
              max_d     = head_i.sample;
              max_idx_d = head_i.index;
              phase_d   = hpvd_pkg::PH_MAX;
            end else if (d_start < -thr_ext) begin
              min_d     = head_i.sample;
              min_idx_d = head_i.index;
              phase_d   = hpvd_pkg::PH_MIN;
            end
          end
          hpvd_pkg::PH_MAX: begin
            if (head_i.sample > max_q) begin
              max_d     = head_i.sample;
              max_idx_d = head_i.index;
            end
            // a new maximum gives a negative drop, so no peak then
            if (drop > thr_ext) begin
              emit      = 1'b1;
              kind_d    = hpvd_pkg::KIND_PEAK;
              idx_d     = max_idx_q;
              val_d     = max_q;
              min_d     = head_i.sample;
              min_idx_d = head_i.index;
              phase_d   = hpvd_pkg::PH_MIN;
            end
          end
          hpvd_pkg::PH_MIN: begin
            if (head_i.sample < min_q) begin
              min_d     = head_i.sample;
              min_idx_d = head_i.index;
            end
            if (rise > thr_ext) begin
              emit      = 1'b1;
              kind_d    = hpvd_pkg::KIND_VALLEY;
              idx_d     = min_idx_q;
              val_d     = min_q;
              max_d     = head_i.sample;
              max_idx_d = head_i.index;
              phase_d   = hpvd_pkg::PH_MAX;
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (pop) begin
      out_valid_d = emit;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= hpvd_pkg::PH_SEARCH;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // tracker and event payload
  always_ff @(posedge clk_i) begin
    start_q   <= start_d;
    max_q     <= max_d;
    max_idx_q <= max_idx_d;
    min_q     <= min_d;
    min_idx_q <= min_idx_d;
    kind_q    <= kind_d;
    idx_q     <= idx_d;
    val_q     <= val_d;
  end

  assign status_o.phase = phase_q;
  assign status_o.pop   = pop;
  assign out_valid_o    = out_valid_q;
  assign event_kind_o   = kind_q;
  assign event_index_o  = idx_q;
  assign event_value_o  = val_q;

endmodule

/* rtl/hysteresis_peak_valley_detector_top.sv */
// Hysteresis peak/valley detector, top level. Takes one signed Q15.8 sample per
// beat and reports the start point, then each confirmed peak and valley with its
// sample number and value. Sustained rate is one sample per clock while the output
// is not stalled; a sample's event passes the queue and then the registered output
// stage before it is on the output. The rate is set by the tracker in the back
// end, which does its compare and update combinationally. A two-entry queue
// separates intake from the tracker and a registered output stage separates the
// tracker from the consumer, so a stalled output fills the queue before the
// input stalls. The user must write the threshold register over its own port
// only while no sample is in flight; the block does not enforce this.
// depends on hpvd_pkg, hpvd_front, hpvd_queue, hpvd_back and the macros header
`timescale 1ns / 1ps

`include "hysteresis_peak_valley_detector_top_macros.svh"

module hysteresis_peak_valley_detector_top (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [hpvd_pkg::THR_WIDTH-1:0]           hysteresis_threshold_i,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic signed [hpvd_pkg::SAMPLE_WIDTH-1:0] sample_value_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic [hpvd_pkg::KIND_WIDTH-1:0]          event_kind_o,
  output logic [hpvd_pkg::INDEX_WIDTH-1:0]         event_index_o,
  output logic signed [hpvd_pkg::SAMPLE_WIDTH-1:0] event_value_o
);

  localparam logic [hpvd_pkg::THR_WIDTH-1:0] THR_RESET = hpvd_pkg::THR_WIDTH'(2560);

  logic [hpvd_pkg::THR_WIDTH-1:0]   thr_q;
  logic                             push;
  hpvd_pkg::entry_t                 entry, head;
  hpvd_pkg::queue_status_t          q_status;
  hpvd_pkg::back_status_t           b_status;
  logic                             start_beat;
  logic                             searching;
  logic                             q_grow;
  logic [hpvd_pkg::QUEUE_CNT_W-1:0] q_count;

  // threshold register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thr_q <= hysteresis_threshold_i;
    end
  end

  hpvd_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .sample_value_i,
    .queue_full_i (q_status.full),
    .push_o       (push),
    .entry_o      (entry)
  );

  hpvd_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i   (push),
    .entry_i  (entry),
    .pop_i    (b_status.pop),
    .head_o   (head),
    .status_o (q_status)
  );

  hpvd_back u_back (
    .clk_i,
    .rst_ni,
    .threshold_i  (thr_q),
    .head_valid_i (!q_status.empty),
    .head_i       (head),
    .status_o     (b_status),
    .out_valid_o,
    .out_ready_i,
    .event_kind_o,
    .event_index_o,
    .event_value_o
  );

  // terms for the checks
  assign start_beat = out_valid_o && (event_kind_o == hpvd_pkg::KIND_START);
  assign searching  = (b_status.phase == hpvd_pkg::PH_SEARCH);
  assign q_grow     = q_status.push && !b_status.pop;
  assign q_count    = q_status.count;

  // checks
  `HPVD_ASSERT_NOW(a_start_index_zero, start_beat, event_index_o == '0, "start beat index nonzero")
  `HPVD_ASSERT_NOW(a_start_while_search, start_beat, searching, "start beat after tracking began")
  `HPVD_ASSERT_NEXT(a_queue_grows, q_grow, q_count == $past(q_count) + 1'b1, "queue did not grow")

endmodule

/* bench/tb_hysteresis_peak_valley_detector_top.sv */
// testbench for hysteresis_peak_valley_detector_top: directed and random sample
// streams checked beat by beat against a built-in tracker model
// depends on hpvd_pkg and the detector rtl
`timescale 1ns / 1ps

module tb_hysteresis_peak_valley_detector_top;

  localparam int unsigned SW = hpvd_pkg::SAMPLE_WIDTH;
  localparam int unsigned IW = hpvd_pkg::INDEX_WIDTH;
  localparam int unsigned TW = hpvd_pkg::THR_WIDTH;
  localparam int unsigned KW = hpvd_pkg::KIND_WIDTH;

  localparam logic [TW-1:0] DEFAULT_THRESHOLD = TW'(2560);
  localparam logic [TW-1:0] THRESHOLD_MAX     = '1;
  localparam longint SAMPLE_MAX   = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint SAMPLE_MIN   = -(longint'(1) <<< (SW - 1));
  localparam int     DRAIN_CYCLES = 8;
  localparam int     STALL_LIMIT  = 2000;
  localparam int     REPORT_LIMIT = 10;
  localparam int     RANDOM_PHASES     = 8;
  localparam int     ITEMS_PER_PHASE   = 200;

  typedef enum int {
    READY_ALWAYS,
    READY_RANDOM,
    READY_PERIODIC,
    READY_SLOW
  } ready_mode_e;

  typedef struct packed {
    hpvd_pkg::kind_e      kind;
    logic [IW-1:0]        index;
    logic signed [SW-1:0] value;
  } extreme_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [TW-1:0]        hysteresis_threshold_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic signed [SW-1:0] sample_value_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [KW-1:0]        event_kind_o;
  logic [IW-1:0]        event_index_o;
  logic signed [SW-1:0] event_value_o;

  hysteresis_peak_valley_detector_top dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .hysteresis_threshold_i(hysteresis_threshold_i),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .sample_value_i        (sample_value_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .event_kind_o          (event_kind_o),
    .event_index_o         (event_index_o),
    .event_value_o         (event_value_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // tracker model state
  logic [TW-1:0]        threshold_model = DEFAULT_THRESHOLD;
  bit                   tracker_started = 1'b0;
  hpvd_pkg::phase_e     tracker_phase = hpvd_pkg::PH_SEARCH;
  logic [IW-1:0]        sample_num = '0;
  logic signed [SW-1:0] origin_value = '0;
  logic signed [SW-1:0] peak_value = '0;
  logic [IW-1:0]        peak_index = '0;
  logic signed [SW-1:0] valley_value = '0;
  logic [IW-1:0]        valley_index = '0;

  extreme_t pending_extremes[$];
  int       error_count = 0;

  // stimulus shaping
  ready_mode_e ready_mode = READY_ALWAYS;
  bit          sender_gappy = 1'b0;
  int          burst_left = 1;
  longint      walk_level = 0;
  longint      walk_dir = 1;
  int          walk_run = 0;

  // update the tracker model with one accepted sample, queue any extreme it confirms
  task automatic track_sample(input logic signed [SW-1:0] s);
    longint sv;
    longint thr;
    longint swing;
    sv  = longint'(s);
    thr = longint'(threshold_model);
    if (!tracker_started) begin
      tracker_started = 1'b1;
      origin_value = s;
      pending_extremes.push_back('{hpvd_pkg::KIND_START, sample_num, s});
    end else begin
      case (tracker_phase)
        hpvd_pkg::PH_SEARCH: begin
          swing = sv - longint'(origin_value);
          if ((swing < 0 ? -swing : swing) > thr) begin
            if (swing > 0) begin
              peak_value    = s;
              peak_index    = sample_num;
              tracker_phase = hpvd_pkg::PH_MAX;
            end else begin
              valley_value  = s;
              valley_index  = sample_num;
              tracker_phase = hpvd_pkg::PH_MIN;
            end
          end
        end
        hpvd_pkg::PH_MAX: begin
          if (s > peak_value) begin
            peak_value = s;
            peak_index = sample_num;
          end
          if (longint'(peak_value) - sv > thr) begin
            pending_extremes.push_back('{hpvd_pkg::KIND_PEAK, peak_index, peak_value});
            valley_value  = s;
            valley_index  = sample_num;
            tracker_phase = hpvd_pkg::PH_MIN;
          end
        end
        hpvd_pkg::PH_MIN: begin
          if (s < valley_value) begin
            valley_value = s;
            valley_index = sample_num;
          end
          if (sv - longint'(valley_value) > thr) begin
            pending_extremes.push_back('{hpvd_pkg::KIND_VALLEY, valley_index, valley_value});
            peak_value    = s;
            peak_index    = sample_num;
            tracker_phase = hpvd_pkg::PH_MAX;
          end
        end
        default: ;
      endcase
    end
    // counter saturates
    if (sample_num != '1) sample_num++;
  endtask

  function automatic longint clamp_sample(input longint v);
    if (v > SAMPLE_MAX) return SAMPLE_MAX;
    if (v < SAMPLE_MIN) return SAMPLE_MIN;
    return v;
  endfunction

  // send one sample, bursts and gaps on the input side
  task automatic send_sample(input logic signed [SW-1:0] s);
    in_valid_i     <= 1'b1;
    sample_value_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    track_sample(s);
    if (sender_gappy) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
        burst_left = $urandom_range(1, 40);
      end
    end
  endtask

  // hold the input off until every queued extreme has come out
  task automatic hold_until_results_done();
    in_valid_i <= 1'b0;
    while (pending_extremes.size() != 0) @(posedge clk_i);
  endtask

  // fully idle: results done plus pipeline flush for samples that report nothing
  task automatic wait_drained();
    hold_until_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [TW-1:0] thr);
    wait_drained();
    cfg_valid_i            <= 1'b1;
    hysteresis_threshold_i <= thr;
    do @(posedge clk_i); while (!cfg_ready_o);
    threshold_model = thr;
    cfg_valid_i <= 1'b0;
  endtask

  // mostly a triangle walk around the threshold, plus boundary hits and noise
  task automatic next_sample(output logic signed [SW-1:0] s);
    int          pick;
    int unsigned step_max;
    longint      cand;
    pick     = $urandom_range(0, 99);
    step_max = threshold_model / 3 + 2;
    if (pick < 50) begin
      if (walk_run <= 0) begin
        walk_dir = -walk_dir;
        walk_run = $urandom_range(2, 12);
      end
      walk_run--;
      cand = clamp_sample(walk_level + walk_dir * longint'($urandom_range(0, step_max)));
      if (cand == SAMPLE_MAX || cand == SAMPLE_MIN) walk_run = 0;
      walk_level = cand;
      s = SW'(cand);
    end else if (pick < 75) begin
      // land on, just inside or just past the confirm boundary
      case (tracker_phase)
        hpvd_pkg::PH_MAX: cand = longint'(peak_value) - longint'(threshold_model);
        hpvd_pkg::PH_MIN: cand = longint'(valley_value) + longint'(threshold_model);
        default: begin
          if ($urandom_range(0, 1))
            cand = longint'(origin_value) + longint'(threshold_model);
          else
            cand = longint'(origin_value) - longint'(threshold_model);
        end
      endcase
      cand = clamp_sample(cand + longint'($urandom_range(0, 2)) - 1);
      walk_level = cand;
      s = SW'(cand);
    end else if (pick < 85) begin
      s = SW'($urandom);
    end else begin
      s = SW'(clamp_sample(walk_level + longint'($urandom_range(0, 2)) - 1));
    end
  endtask

  // receiver stall pattern
  logic [7:0] stall_tick = '0;
  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 8'd1;
    case (ready_mode)
      READY_ALWAYS:   out_ready_i <= 1'b1;
      READY_RANDOM:   out_ready_i <= ($urandom_range(0, 3) != 0);
      READY_PERIODIC: out_ready_i <= (stall_tick[2:0] != 3'd5) && (stall_tick[5:4] != 2'd2);
      READY_SLOW:     out_ready_i <= (stall_tick[4:0] > 5'd24);
      default:        out_ready_i <= 1'b1;
    endcase
  end

  function automatic void note_failure(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("%s", msg);
  endfunction

  // compare each output beat with the oldest queued extreme
  always @(posedge clk_i) begin : check_extremes
    extreme_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_extremes.size() == 0) begin
        note_failure($sformatf("unexpected beat: kind %0d index %0d value %0d",
                               event_kind_o, event_index_o, event_value_o));
      end else begin
        want = pending_extremes.pop_front();
        if (event_kind_o !== want.kind || event_index_o !== want.index ||
            event_value_o !== want.value)
          note_failure($sformatf(
            "mismatch: expected kind %0d index %0d value %0d, got kind %0d index %0d value %0d",
            want.kind, want.index, want.value,
            event_kind_o, event_index_o, event_value_o));
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // start point, equal swings in search, both extremes at the sample limits
  task automatic test_search_and_extremes();
    ready_mode <= READY_RANDOM;
    send_sample(24'sd0);
    send_sample(-24'sd2560);
    send_sample(24'sd2560);
    send_sample(24'sd2561);
    send_sample(24'sd8388607);
    send_sample(24'sd8388607 - 24'sd2560);
    send_sample(24'sd8388607 - 24'sd2561);
    send_sample(-24'sd8388608);
    send_sample(-24'sd8388608 + 24'sd2560);
    send_sample(-24'sd8388608 + 24'sd2561);
  endtask

  // zero threshold: any one-lsb turn confirms, a flat sample does not
  task automatic test_threshold_zero();
    write_threshold('0);
    send_sample(-24'sd8385047);
    send_sample(-24'sd8385046);
    send_sample(-24'sd8385047);
    send_sample(-24'sd8385047);
    send_sample(-24'sd8385046);
  endtask

  // largest threshold: only a full-scale swing confirms
  task automatic test_threshold_max();
    write_threshold(THRESHOLD_MAX);
    send_sample(24'sd8388607);
    send_sample(24'sd0);
    send_sample(-24'sd8388608);
    send_sample(24'sd8388607);
  endtask

  task automatic test_random_streams();
    logic signed [SW-1:0] s;
    logic [TW-1:0]        thr;
    for (int k = 0; k < RANDOM_PHASES; k++) begin
      case (k)
        0:       thr = DEFAULT_THRESHOLD;
        1:       thr = TW'($urandom_range(0, 255));
        2:       thr = TW'($urandom);
        3:       thr = '0;
        4:       thr = THRESHOLD_MAX;
        5:       thr = TW'($urandom_range(256, 65535));
        6:       thr = TW'(1);
        default: thr = TW'($urandom_range(1024, 1048575));
      endcase
      write_threshold(thr);
      ready_mode   <= ready_mode_e'(k % 4);
      sender_gappy = (k % 3) != 0;
      burst_left   = $urandom_range(1, 40);
      walk_level   = clamp_sample(longint'(sample_value_i));
      repeat (ITEMS_PER_PHASE) begin
        next_sample(s);
        send_sample(s);
      end
    end
  endtask

  // sender stops mid-stream until every queued extreme is out, then resumes
  task automatic test_pause_for_results();
    logic signed [SW-1:0] s;
    write_threshold(DEFAULT_THRESHOLD);
    ready_mode   <= READY_SLOW;
    sender_gappy = 1'b0;
    repeat (20) begin
      next_sample(s);
      send_sample(s);
    end
    hold_until_results_done();
    repeat (20) begin
      next_sample(s);
      send_sample(s);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_search_and_extremes();
    test_threshold_zero();
    test_threshold_max();
    test_random_streams();
    test_pause_for_results();
    wait_drained();

    if (error_count == 0 && pending_extremes.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

/* hysteresis_peak_valley_detector_top.f */
+incdir+rtl
rtl/hpvd_pkg.sv
rtl/hpvd_front.sv
rtl/hpvd_queue.sv
rtl/hpvd_back.sv
rtl/hysteresis_peak_valley_detector_top.sv
bench/tb_hysteresis_peak_valley_detector_top.sv
